@@ rtl/bsg_pkg.sv @@
// Package for the blocked serpentine grid index generator.
// Holds shared widths, the front-to-back queue head type and the block side table builder.
// No dependencies.
package bsg_pkg;

    localparam int MAX_PATCH_QUADS_DEF = 64;
    localparam int MAX_BLOCK_QUADS_DEF = 8;
    localparam int NW        = 7;
    localparam int IW        = 16;
    localparam int TAB_DEPTH = 1 << NW;

    typedef logic [NW-1:0] cnt_t;
    typedef logic [IW-1:0] idx_t;
    typedef cnt_t side_tab_t [TAB_DEPTH];

    typedef struct packed {
        logic valid;
        logic restart;
    } q_head_t;

    // Elaboration-time table: largest divisor of n not above max_block,
    // or the matching quotient when want_bps is set.
    function automatic side_tab_t build_side_tab(int max_block, bit want_bps);
        side_tab_t t;
        int        c;
        int        s;
        int        q;
        bit        found;
        for (int n = 0; n < TAB_DEPTH; n++) begin
            s     = 1;
            q     = n;
            found = 1'b0;
            c     = (n < max_block) ? n : max_block;
            for (; c > 1; c--) begin
                for (int k = 1; k <= n; k++) begin
                    if (!found && (k * c == n)) begin
                        s     = c;
                        q     = k;
                        found = 1'b1;
                    end
                end
            end
            t[n] = want_bps ? NW'(q) : NW'(s);
        end
        return t;
    endfunction

endpackage

@@ rtl/bsg_front.sv @@
// Front of the index generator: accepts items and holds them in a two-entry queue.
// Depends on bsg_pkg.
module bsg_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              restart,
    input  logic              q_pop,
    output bsg_pkg::q_head_t  q_head
);

    logic       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;

    assign in_stall       = (count_reg == 2'd2);
    assign push           = in_valid && !in_stall;
    assign q_head.valid   = (count_reg != 2'd0);
    assign q_head.restart = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= restart;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, q_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ rtl/bsg_back.sv @@
// Back of the index generator: sweep counters, address arithmetic, output register.
// Depends on bsg_pkg.
module bsg_back #(
    parameter int MAX_PATCH_QUADS = bsg_pkg::MAX_PATCH_QUADS_DEF,
    parameter int MAX_BLOCK_QUADS = bsg_pkg::MAX_BLOCK_QUADS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bsg_pkg::q_head_t  q_head,
    output logic              q_pop,
    input  logic              cfg_we,
    input  bsg_pkg::cnt_t     cfg_data,
    output logic              out_valid,
    input  logic              out_stall,
    output bsg_pkg::idx_t     idx_a,
    output bsg_pkg::idx_t     idx_b,
    output bsg_pkg::idx_t     idx_c,
    output bsg_pkg::idx_t     idx_d,
    output bsg_pkg::idx_t     idx_e,
    output bsg_pkg::idx_t     idx_f,
    output logic              last_quad,
    output logic              config_error
);

    localparam bsg_pkg::side_tab_t SIDE_TAB = bsg_pkg::build_side_tab(MAX_BLOCK_QUADS, 1'b0);
    localparam bsg_pkg::side_tab_t BPS_TAB  = bsg_pkg::build_side_tab(MAX_BLOCK_QUADS, 1'b1);
    localparam logic [bsg_pkg::NW:0] MAX_N  = (bsg_pkg::NW + 1)'(MAX_PATCH_QUADS);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ADDR, ST_OUT} state_t;

    state_t              state_reg;
    logic                sweep_active_reg;
    bsg_pkg::cnt_t       patch_quads_reg;
    bsg_pkg::cnt_t       n_reg;
    bsg_pkg::cnt_t       bs_reg;
    bsg_pkg::cnt_t       bps_reg;
    bsg_pkg::cnt_t       cb_reg;
    bsg_pkg::cnt_t       bstep_reg;
    bsg_pkg::cnt_t       rstep_reg;
    bsg_pkg::cnt_t       cstep_reg;
    logic                xf_reg;
    bsg_pkg::cnt_t       by_reg;
    bsg_pkg::cnt_t       ly_reg;
    bsg_pkg::cnt_t       lx_reg;
    bsg_pkg::cnt_t       cbp_reg;
    logic                err_reg;
    logic                last_reg;
    bsg_pkg::cnt_t       qy_reg;
    bsg_pkg::cnt_t       qx_reg;
    bsg_pkg::idx_t       ll_reg;
    logic                ov_reg;
    bsg_pkg::idx_t       oa_reg;
    bsg_pkg::idx_t       oc_reg;
    bsg_pkg::idx_t       of_reg;
    logic                olast_reg;
    logic                oerr_reg;

    logic                start;
    logic                n_valid;
    bsg_pkg::cnt_t       bs;
    bsg_pkg::cnt_t       bps;
    bsg_pkg::cnt_t       cb;
    bsg_pkg::cnt_t       bstep;
    bsg_pkg::cnt_t       rstep;
    bsg_pkg::cnt_t       cstep;
    logic                xf;
    logic                yf;
    bsg_pkg::cnt_t       block_y;
    bsg_pkg::cnt_t       local_y;
    bsg_pkg::cnt_t       local_x;
    bsg_pkg::cnt_t       cb_next;
    bsg_pkg::cnt_t       bstep_next;
    bsg_pkg::cnt_t       rstep_next;
    bsg_pkg::cnt_t       cstep_next;
    logic                xf_next;
    logic                last_next;
    logic [13:0]         qy_next;
    logic [13:0]         qx_next;
    logic [bsg_pkg::NW:0] row_len;
    logic                out_load;

    assign q_pop    = (state_reg == ST_IDLE) && q_head.valid;
    assign out_load = (state_reg == ST_OUT) && (!ov_reg || !out_stall);
    assign row_len  = {1'b0, n_reg} + 8'd1;
    assign qy_next  = by_reg * bs_reg + 14'(ly_reg);
    assign qx_next  = cbp_reg * bs_reg + 14'(lx_reg);

    always_comb
    begin
        start   = q_head.restart || !sweep_active_reg;
        n_valid = (patch_quads_reg >= 7'd2) && ({1'b0, patch_quads_reg} <= MAX_N)
                  && !patch_quads_reg[0];
        bs      = start ? SIDE_TAB[patch_quads_reg] : bs_reg;
        bps     = start ? BPS_TAB[patch_quads_reg] : bps_reg;
        cb      = start ? '0 : cb_reg;
        bstep   = start ? '0 : bstep_reg;
        rstep   = start ? '0 : rstep_reg;
        cstep   = start ? '0 : cstep_reg;
        xf      = start ? 1'b1 : xf_reg;
        yf      = !cb[0];
        block_y = yf ? bstep : bps - 7'd1 - bstep;
        local_y = yf ? rstep : bs - 7'd1 - rstep;
        local_x = xf ? cstep : bs - 7'd1 - cstep;

        cstep_next = cstep + 7'd1;
        rstep_next = rstep;
        bstep_next = bstep;
        cb_next    = cb;
        xf_next    = xf;
        last_next  = 1'b0;
        if (cstep_next >= bs)
        begin
            cstep_next = '0;
            xf_next    = !xf;
            rstep_next = rstep + 7'd1;
            if (rstep_next >= bs)
            begin
                rstep_next = '0;
                bstep_next = bstep + 7'd1;
                if (bstep_next >= bps)
                begin
                    bstep_next = '0;
                    cb_next    = cb + 7'd1;
                    if (cb_next >= bps)
                    begin
                        cb_next   = '0;
                        last_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            by_reg  <= block_y;
            ly_reg  <= local_y;
            lx_reg  <= local_x;
            cbp_reg <= cb;
        end
        if (state_reg == ST_MUL)
        begin
            qy_reg <= qy_next[6:0];
            qx_reg <= qx_next[6:0];
        end
        if (state_reg == ST_ADDR)
        begin
            ll_reg <= bsg_pkg::IW'(qy_reg) * bsg_pkg::IW'(row_len) + bsg_pkg::IW'(qx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sweep_active_reg <= 1'b0;
            patch_quads_reg  <= 7'd16;
            n_reg            <= '0;
            bs_reg           <= '0;
            bps_reg          <= '0;
            cb_reg           <= '0;
            bstep_reg        <= '0;
            rstep_reg        <= '0;
            cstep_reg        <= '0;
            xf_reg           <= 1'b1;
            err_reg          <= 1'b0;
            last_reg         <= 1'b0;
            ov_reg           <= 1'b0;
            oa_reg           <= '0;
            oc_reg           <= '0;
            of_reg           <= '0;
            olast_reg        <= 1'b0;
            oerr_reg         <= 1'b0;
        end
        else
        begin
            if (ov_reg && !out_stall && !out_load)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (start && !n_valid)
                        begin
                            sweep_active_reg <= 1'b0;
                            err_reg          <= 1'b1;
                            last_reg         <= 1'b0;
                            state_reg        <= ST_OUT;
                        end
                        else
                        begin
                            if (start)
                            begin
                                n_reg <= patch_quads_reg;
                            end
                            bs_reg           <= bs;
                            bps_reg          <= bps;
                            cb_reg           <= cb_next;
                            bstep_reg        <= bstep_next;
                            rstep_reg        <= rstep_next;
                            cstep_reg        <= cstep_next;
                            xf_reg           <= xf_next;
                            sweep_active_reg <= !last_next;
                            err_reg          <= 1'b0;
                            last_reg         <= last_next;
                            state_reg        <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_ADDR;
                end
                ST_ADDR:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        ov_reg    <= 1'b1;
                        olast_reg <= last_reg;
                        oerr_reg  <= err_reg;
                        if (err_reg)
                        begin
                            oa_reg <= '0;
                            oc_reg <= '0;
                            of_reg <= '0;
                        end
                        else
                        begin
                            oa_reg <= ll_reg;
                            oc_reg <= ll_reg + bsg_pkg::IW'(row_len) + 16'd1;
                            of_reg <= ll_reg + bsg_pkg::IW'(row_len);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (cfg_we)
            begin
                patch_quads_reg  <= cfg_data;
                sweep_active_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = ov_reg;
    assign idx_a        = oa_reg;
    assign idx_b        = oerr_reg ? '0 : oa_reg + 16'd1;
    assign idx_c        = oc_reg;
    assign idx_d        = oa_reg;
    assign idx_e        = oc_reg;
    assign idx_f        = of_reg;
    assign last_quad    = olast_reg;
    assign config_error = oerr_reg;

endmodule

@@ rtl/blocked_serpentine_grid_index_gen.sv @@
// Top level of the blocked serpentine grid index generator.
// Path: an item is queued, popped in the idle state, goes through the two multiply steps and is loaded.
// The back sequencer takes no new item until the last one is loaded; an error item skips the multiply steps.
// Reset: queue empty, no sweep active, patch_quads = 16, output register empty.
// Depends on bsg_pkg, bsg_front, bsg_back.
module blocked_serpentine_grid_index_gen #(
    parameter int MAX_PATCH_QUADS = bsg_pkg::MAX_PATCH_QUADS_DEF,
    parameter int MAX_BLOCK_QUADS = bsg_pkg::MAX_BLOCK_QUADS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          restart,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  bsg_pkg::cnt_t patch_quads,
    output logic          out_valid,
    input  logic          out_stall,
    output bsg_pkg::idx_t idx_a,
    output bsg_pkg::idx_t idx_b,
    output bsg_pkg::idx_t idx_c,
    output bsg_pkg::idx_t idx_d,
    output bsg_pkg::idx_t idx_e,
    output bsg_pkg::idx_t idx_f,
    output logic          last_quad,
    output logic          config_error
);

    bsg_pkg::q_head_t q_head;
    logic             q_pop;

    assign cfg_ready = 1'b1;

    bsg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .restart  (restart),
        .q_pop    (q_pop),
        .q_head   (q_head)
    );

    bsg_back #(
        .MAX_PATCH_QUADS (MAX_PATCH_QUADS),
        .MAX_BLOCK_QUADS (MAX_BLOCK_QUADS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (patch_quads),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .idx_a        (idx_a),
        .idx_b        (idx_b),
        .idx_c        (idx_c),
        .idx_d        (idx_d),
        .idx_e        (idx_e),
        .idx_f        (idx_f),
        .last_quad    (last_quad),
        .config_error (config_error)
    );

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && config_error |-> idx_a == 16'd0 && idx_c == 16'd0 && !last_quad)
        else $error("error item with nonzero fields");

    a_quad_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !config_error |-> idx_b == idx_a + 16'd1 && idx_e == idx_f + 16'd1)
        else $error("quad corners inconsistent");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head.valid)
        else $error("pop from empty queue");

endmodule

@@ dv/tb.sv @@
// Testbench for blocked_serpentine_grid_index_gen: a checker class predicts each quad's
// triangle indices from the patch size and compares them with the block's results.
// Depends on bsg_pkg and the RTL top level only.
typedef struct packed {
    bsg_pkg::idx_t a;
    bsg_pkg::idx_t b;
    bsg_pkg::idx_t c;
    bsg_pkg::idx_t d;
    bsg_pkg::idx_t e;
    bsg_pkg::idx_t f;
    logic          last;
    logic          err;
} quad_t;

class serpentine_checker;
    bsg_pkg::cnt_t patch;
    bsg_pkg::cnt_t side;
    bsg_pkg::cnt_t sides;
    bsg_pkg::cnt_t bcol;
    bsg_pkg::cnt_t bstep;
    bsg_pkg::cnt_t rstep;
    bsg_pkg::cnt_t cstep;
    bit            xfwd;
    bit            active;
    quad_t         expected_quads[$];
    int            failures;

    function new();
        patch    = 16;
        side     = 0;
        sides    = 0;
        bcol     = 0;
        bstep    = 0;
        rstep    = 0;
        cstep    = 0;
        xfwd     = 1'b1;
        active   = 1'b0;
        failures = 0;
    endfunction

    function void set_patch(bsg_pkg::cnt_t v);
        patch  = v;
        active = 1'b0;
    endfunction

    function int outstanding();
        return expected_quads.size();
    endfunction

    function void add_expected(quad_t q);
        expected_quads.insert(expected_quads.size(), q);
    endfunction

    // Works out the quad that one item yields and advances the sweep.
    function void note_step(logic rs);
        quad_t q;
        int    lim;
        int    row_len;
        int    by;
        int    ly;
        int    lx;
        int    qx;
        int    qy;
        int    ll;
        int    ul;
        bit    yfwd;
        q = '0;
        if (rs || !active) begin
            if (patch < 2 || patch > bsg_pkg::MAX_PATCH_QUADS_DEF || patch[0]) begin
                q.err  = 1'b1;
                active = 1'b0;
                add_expected(q);
                return;
            end
            lim  = (patch < bsg_pkg::MAX_BLOCK_QUADS_DEF) ? patch
                                                           : bsg_pkg::MAX_BLOCK_QUADS_DEF;
            side = 1;
            for (int c = 2; c <= lim; c++)
            begin
                if (patch % c == 0)
                begin
                    side = bsg_pkg::NW'(c);
                end
            end
            sides  = patch / side;
            bcol   = 0;
            bstep  = 0;
            rstep  = 0;
            cstep  = 0;
            xfwd   = 1'b1;
            active = 1'b1;
        end
        row_len = side * sides + 1;
        yfwd    = !bcol[0];
        by      = yfwd ? bstep : sides - 1 - bstep;
        ly      = yfwd ? rstep : side - 1 - rstep;
        lx      = xfwd ? cstep : side - 1 - cstep;
        qy      = by * side + ly;
        qx      = bcol * side + lx;
        ll      = (qy * row_len + qx) & 16'hFFFF;
        ul      = (ll + row_len) & 16'hFFFF;
        q.a     = bsg_pkg::IW'(ll);
        q.b     = bsg_pkg::IW'(ll + 1);
        q.c     = bsg_pkg::IW'(ul + 1);
        q.d     = bsg_pkg::IW'(ll);
        q.e     = bsg_pkg::IW'(ul + 1);
        q.f     = bsg_pkg::IW'(ul);
        cstep++;
        if (cstep >= side)
        begin
            cstep = 0;
            xfwd  = !xfwd;
            rstep++;
            if (rstep >= side)
            begin
                rstep = 0;
                bstep++;
                if (bstep >= sides)
                begin
                    bstep = 0;
                    bcol++;
                    if (bcol >= sides)
                    begin
                        bcol   = 0;
                        q.last = 1'b1;
                        active = 1'b0;
                    end
                end
            end
        end
        add_expected(q);
    endfunction

    function string describe(quad_t q);
        return $sformatf("%0d %0d %0d / %0d %0d %0d last=%0b err=%0b",
                         q.a, q.b, q.c, q.d, q.e, q.f, q.last, q.err);
    endfunction

    function void check_quad(quad_t got);
        quad_t want;
        if (expected_quads.size() == 0)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("unexpected result: %s", describe(got));
            end
            return;
        end
        want = expected_quads.pop_front();
        if (want.a != got.a || want.b != got.b || want.c != got.c || want.d != got.d ||
            want.e != got.e || want.f != got.f || want.last != got.last ||
            want.err != got.err)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("mismatch: expected %s, got %s", describe(want), describe(got));
            end
        end
    endfunction
endclass

module tb;
    localparam int DEAD_LIMIT = 4000;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic          restart;
    logic          cfg_valid;
    logic          cfg_ready;
    bsg_pkg::cnt_t patch_quads;
    logic          out_valid;
    logic          out_stall;
    bsg_pkg::idx_t idx_a;
    bsg_pkg::idx_t idx_b;
    bsg_pkg::idx_t idx_c;
    bsg_pkg::idx_t idx_d;
    bsg_pkg::idx_t idx_e;
    bsg_pkg::idx_t idx_f;
    logic          last_quad;
    logic          config_error;

    serpentine_checker chk = new();
    bit                no_gaps = 1'b0;
    int                dead_cycles = 0;

    blocked_serpentine_grid_index_gen DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .patch_quads  (patch_quads),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .idx_a        (idx_a),
        .idx_b        (idx_b),
        .idx_c        (idx_c),
        .idx_d        (idx_d),
        .idx_e        (idx_e),
        .idx_f        (idx_f),
        .last_quad    (last_quad),
        .config_error (config_error)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= !no_gaps && ($urandom_range(0, 99) < 17);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                chk.set_patch(patch_quads);
            end
            if (in_valid && !in_stall)
            begin
                chk.note_step(restart);
            end
            if (out_valid && !out_stall)
            begin
                chk.check_quad({idx_a, idx_b, idx_c, idx_d, idx_e, idx_f,
                                last_quad, config_error});
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
            begin
                dead_cycles <= 0;
            end
            else
            begin
                dead_cycles <= dead_cycles + 1;
            end
            if (dead_cycles >= DEAD_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_item(input logic rs);
        if (!no_gaps)
        begin
            while ($urandom_range(0, 99) < 17)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        restart  <= rs;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Lets every outstanding quad drain before the patch size changes.
    task automatic drain();
        in_valid <= 1'b0;
        while (chk.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_patch(input bsg_pkg::cnt_t v);
        patch_quads <= v;
        cfg_valid   <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int            sent;
        int            count;
        int            rpct;
        int            sel;
        int            phase;
        bsg_pkg::cnt_t n;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        restart     <= 1'b0;
        cfg_valid   <= 1'b0;
        patch_quads <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size, sweep starts on its own, then a restart mid-sweep
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        drain();
        write_patch(7'd0);
        send_item(1'b0);
        send_item(1'b1);
        drain();
        write_patch(7'd127);
        send_item(1'b0);
        drain();
        write_patch(7'd65);
        send_item(1'b1);
        drain();
        write_patch(7'd66);
        send_item(1'b0);
        drain();
        write_patch(7'd1);
        send_item(1'b0);
        drain();
        // smallest grid: full sweep, wrap to a new sweep, restart
        write_patch(7'd2);
        repeat (5) send_item(1'b0);
        send_item(1'b1);
        drain();
        write_patch(7'd64);
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);

        sent  = 0;
        phase = 0;
        while (sent < 800)
        begin
            drain();
            no_gaps = (phase == 0) || ($urandom_range(0, 7) == 0);
            sel     = $urandom_range(0, 99);
            if (sel < 12)
            begin
                do
                begin
                    n = bsg_pkg::NW'($urandom_range(0, 127));
                end
                while (n >= 2 && n <= 64 && !n[0]);
                count = $urandom_range(1, 8);
            end
            else if (sel < 18)
            begin
                case ($urandom_range(0, 3))
                    0: n = 48;
                    1: n = 56;
                    2: n = 62;
                    default: n = 64;
                endcase
                count = $urandom_range(20, 120);
            end
            else
            begin
                n     = bsg_pkg::NW'(2 * $urandom_range(1, 13));
                count = n * n + $urandom_range(0, n);
                if (count > 420)
                begin
                    count = $urandom_range(50, 400);
                end
            end
            if (count > 800 - sent)
            begin
                count = 800 - sent;
            end
            // sometimes keep the running sweep instead of rewriting the size
            if (phase == 0 || $urandom_range(0, 4) != 0)
            begin
                write_patch(n);
            end
            rpct = ($urandom_range(0, 3) == 0) ? 3 : 0;
            for (int k = 0; k < count; k++)
            begin
                send_item($urandom_range(0, 99) < rpct);
            end
            sent  += count;
            phase += 1;
        end

        in_valid <= 1'b0;
        while (chk.outstanding() != 0)
        begin
            @(posedge clk);
        end
        no_gaps = 1'b0;
        repeat (12) @(posedge clk);
        if (chk.failures == 0 && chk.outstanding() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/bsg_pkg.sv
rtl/bsg_front.sv
rtl/bsg_back.sv
rtl/blocked_serpentine_grid_index_gen.sv
dv/tb.sv
